FILE: hw/rtl/itp_pkg.sv
// itp_pkg: types, codes and character constants of the infix to postfix converter
// no dependencies; used by itp_cmp and the top level by scoped names
package itp_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // precedence levels, unknown bytes and '^' bind tightest
  localparam logic [1:0] PREC_ADD = 2'd1;
  localparam logic [1:0] PREC_MUL = 2'd2;
  localparam logic [1:0] PREC_MAX = 2'd3;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } itp_err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_TAIL,
    ST_PUSH,
    ST_FINISH
  } itp_state_e;

  // what the pop loop is doing
  typedef enum logic [1:0] {
    MD_FLUSH,
    MD_CLOSE,
    MD_OPER
  } itp_mode_e;

  // result of the stack top compare
  typedef struct packed {
    logic is_lpar;
    logic pop;
  } itp_cmp_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = PREC_MAX;
    if (c == CH_PLUS || c == CH_MINUS) begin
      p = PREC_ADD;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = PREC_MUL;
    end
    return p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: hw/rtl/itp_ram.sv
// itp_ram: generic single write port, single read port ram with registered read
// no dependencies
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/itp_cmp.sv
// itp_cmp: precedence compare of the stack top against the incoming operator
// depends on itp_pkg
module itp_cmp (
  input  logic [7:0]        top_i,
  input  logic [1:0]        prec_i,
  output itp_pkg::itp_cmp_t res_o
);

  logic lpar;

  assign lpar          = (top_i == itp_pkg::CH_LPAR);
  assign res_o.is_lpar = lpar;
  // left-associative: pop on higher or equal precedence, never past '('
  assign res_o.pop     = !lpar && (itp_pkg::prec_of(top_i) >= prec_i);

endmodule

FILE: hw/rtl/infix_to_postfix_converter.sv
// infix_to_postfix_converter: shunting-yard converter, top level and sequencer
// depends on itp_pkg, itp_ram, itp_cmp
//
// Takes an infix expression one byte per input beat (tlast marks the end of the
// expression; its byte is ignored) and streams the postfix form, one byte per
// output beat, with tlast on the final beat caused by each input and the error
// code in tuser on that beat. '+' '-' '*' '/', ')' and the end beat pop stacked
// operators, each through the fetch, check, emit_a and emit_b states. The pace
// is set by the operator stack, a ram with registered read that is visited once
// per pop, and by the single sequencer that drives one output byte per emit
// cycle while the held byte can move on. The block takes no new beat until all
// beats of the current input are generated; the last one may still sit in the
// output register while the next input is taken.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tlast_i,   // end_expr
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] char_out
  output logic       m_axis_tlast_o,   // last_of_run
  output logic [1:0] m_axis_tuser_o    // [1:0] error_code
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  itp_pkg::itp_state_e state_q, state_d;
  itp_pkg::itp_mode_e  mode_q, mode_d;
  itp_pkg::itp_err_e   err_q, err_d;

  logic [7:0]    char_q, char_d;     // operator being handled
  logic [1:0]    prec_q, prec_d;
  logic [CW-1:0] cnt_q, cnt_d;       // stack fill
  logic [CW-1:0] cnt_m1;

  // one byte held back so that the final beat of an input can carry tlast
  logic       pend_vld_q, pend_vld_d;
  logic [7:0] pend_char_q, pend_char_d;

  // output register
  logic       m_vld_q;
  logic [7:0] m_data_q;
  logic       m_last_q;
  logic [1:0] m_err_q;
  logic       out_free;
  logic       out_load;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] out_err;

  // stack ram
  logic          ram_we, ram_re;
  logic [7:0]    ram_wdata;
  logic [7:0]    top;

  logic                 in_acc;
  logic                 emit_ok;
  logic                 stack_full;
  itp_pkg::itp_cmp_t    cmp;

  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !m_vld_q || m_axis_tready_i;
  // a new byte fits if nothing is held back or the held byte can move on
  assign emit_ok    = !pend_vld_q || out_free;
  assign cnt_m1     = cnt_q - CW'(1);
  assign stack_full = (cnt_q >= CW'(STACK_DEPTH));

  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (top)
  );

  // the one compare unit, reused on every pop iteration
  itp_cmp u_cmp (
    .top_i  (top),
    .prec_i (prec_q),
    .res_o  (cmp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itp_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (s_axis_tlast_i) begin
            state_d = itp_pkg::ST_FETCH;
          end else if (itp_pkg::is_digit(s_axis_tdata_i)
                       || s_axis_tdata_i == itp_pkg::CH_LPAR) begin
            state_d = itp_pkg::ST_FINISH;
          end else if (s_axis_tdata_i == itp_pkg::CH_RPAR) begin
            state_d = itp_pkg::ST_FETCH;
          end else if (itp_pkg::prec_of(s_axis_tdata_i) < itp_pkg::PREC_MAX) begin
            state_d = itp_pkg::ST_FETCH;
          end else begin
            state_d = itp_pkg::ST_PUSH;
          end
        end
      end
      itp_pkg::ST_FETCH: begin
        if (cnt_q == '0) begin
          unique case (mode_q)
            itp_pkg::MD_FLUSH: state_d = itp_pkg::ST_TAIL;
            itp_pkg::MD_CLOSE: state_d = itp_pkg::ST_FINISH;
            default:           state_d = itp_pkg::ST_PUSH;
          endcase
        end else begin
          state_d = itp_pkg::ST_CHECK;
        end
      end
      itp_pkg::ST_CHECK: begin
        unique case (mode_q)
          itp_pkg::MD_FLUSH: state_d = itp_pkg::ST_EMIT_A;
          itp_pkg::MD_CLOSE: state_d = cmp.is_lpar ? itp_pkg::ST_FINISH
                                                   : itp_pkg::ST_EMIT_A;
          default:           state_d = cmp.pop ? itp_pkg::ST_EMIT_A
                                               : itp_pkg::ST_PUSH;
        endcase
      end
      itp_pkg::ST_EMIT_A: if (emit_ok) state_d = itp_pkg::ST_EMIT_B;
      itp_pkg::ST_EMIT_B: if (emit_ok) state_d = itp_pkg::ST_FETCH;
      itp_pkg::ST_TAIL:   if (emit_ok) state_d = itp_pkg::ST_FINISH;
      itp_pkg::ST_PUSH:   state_d = itp_pkg::ST_FINISH;
      itp_pkg::ST_FINISH: begin
        if (out_free || (!pend_vld_q && err_q == itp_pkg::ERR_NONE)) begin
          state_d = itp_pkg::ST_IDLE;
        end
      end
      default: state_d = itp_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    s_axis_tready_o = 1'b0;
    mode_d      = mode_q;
    err_d       = err_q;
    char_d      = char_q;
    prec_d      = prec_q;
    cnt_d       = cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_char_d = pend_char_q;
    out_load    = 1'b0;
    out_char    = pend_char_q;
    out_last    = 1'b0;
    out_err     = itp_pkg::ERR_NONE;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = char_q;

    unique case (state_q)
      itp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          char_d = s_axis_tdata_i;
          prec_d = itp_pkg::prec_of(s_axis_tdata_i);
          err_d  = itp_pkg::ERR_NONE;
          mode_d = itp_pkg::MD_OPER;
          priority if (s_axis_tlast_i) begin
            mode_d = itp_pkg::MD_FLUSH;
          end else if (itp_pkg::is_digit(s_axis_tdata_i)) begin
            pend_vld_d  = 1'b1;
            pend_char_d = s_axis_tdata_i;
          end else if (s_axis_tdata_i == itp_pkg::CH_LPAR) begin
            ram_wdata = s_axis_tdata_i;
            if (stack_full) begin
              err_d = itp_pkg::ERR_OVERFLOW;
            end else begin
              ram_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
            end
          end else if (s_axis_tdata_i == itp_pkg::CH_RPAR) begin
            mode_d = itp_pkg::MD_CLOSE;
          end else begin
            // operator: leading space
            pend_vld_d  = 1'b1;
            pend_char_d = itp_pkg::CH_SPACE;
          end
        end
      end
      itp_pkg::ST_FETCH: begin
        if (cnt_q != '0) begin
          ram_re = 1'b1;
        end else if (mode_q == itp_pkg::MD_CLOSE) begin
          err_d = itp_pkg::ERR_UNMATCHED;
        end
      end
      itp_pkg::ST_CHECK: begin
        if (mode_q != itp_pkg::MD_OPER || cmp.pop) begin
          cnt_d = cnt_m1;
        end
      end
      itp_pkg::ST_EMIT_A, itp_pkg::ST_EMIT_B, itp_pkg::ST_TAIL: begin
        if (emit_ok) begin
          out_load   = pend_vld_q;
          pend_vld_d = 1'b1;
          // popped operator goes before its space on an operator, after it otherwise
          if (state_q == itp_pkg::ST_TAIL) begin
            pend_char_d = itp_pkg::CH_SPACE;
          end else if ((state_q == itp_pkg::ST_EMIT_A) == (mode_q == itp_pkg::MD_OPER)) begin
            pend_char_d = top;
          end else begin
            pend_char_d = itp_pkg::CH_SPACE;
          end
        end
      end
      itp_pkg::ST_PUSH: begin
        if (stack_full) begin
          err_d = itp_pkg::ERR_OVERFLOW;
        end else begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
      end
      itp_pkg::ST_FINISH: begin
        if (out_free) begin
          out_last = 1'b1;
          out_err  = err_q;
          if (pend_vld_q) begin
            out_load   = 1'b1;
            pend_vld_d = 1'b0;
          end else if (err_q != itp_pkg::ERR_NONE) begin
            // error with no byte of its own: a lone nul beat carries it
            out_load = 1'b1;
            out_char = itp_pkg::CH_NUL;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= itp_pkg::ST_IDLE;
      mode_q     <= itp_pkg::MD_OPER;
      err_q      <= itp_pkg::ERR_NONE;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      err_q      <= err_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    prec_q      <= prec_d;
    pend_char_q <= pend_char_d;
    if (out_load) begin
      m_data_q <= out_char;
      m_last_q <= out_last;
      m_err_q  <= out_err;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_err_q;

  // stack fill never passes the depth
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  // nothing is held back between inputs
  a_idle_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itp_pkg::ST_IDLE |-> !pend_vld_q)
    else $error("held byte left over in idle");

  // the stack is only read when it holds something
  a_check_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itp_pkg::ST_CHECK |-> $past(cnt_q) != '0)
    else $error("stack read while empty");

  // an error code only ever rides on a final beat
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && m_err_q != itp_pkg::ERR_NONE |-> m_last_q)
    else $error("error code on a non-final beat");

  // a held byte is never overwritten without moving to the output register
  a_pend_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q && !out_free && state_q != itp_pkg::ST_IDLE |=>
      pend_vld_q && $stable(pend_char_q))
    else $error("held byte lost");

endmodule
